### rtl/assert_macros.svh
// Assertion macros shared by the sync framer RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define SFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define SFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/sfc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the sync framer.
// No dependencies.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned BodyBytesDef = 108;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned OffsetW      = 7;

  localparam logic [31:0] CrcPolyRst  = 32'hEDB8_8320;
  localparam logic [31:0] SyncWordRst = 32'hAA44_121C;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCrcPoly  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSyncWord = 1'b1;

  typedef struct packed {
    logic [7:0]         body_byte;
    logic [OffsetW-1:0] body_offset;
    logic               frame_end;
    logic               crc_good;
  } result_t;

  // Reflected CRC-32 update by one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] t;
    t = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ poly;
      end else begin
        t = t >> 1;
      end
    end
    return {8'h0, crc[31:8]} ^ t;
  endfunction

endpackage

### rtl/sync_frame_crc32_checker_core.sv
// Top level of the sync-word framer with reflected CRC-32 check.
// Depends on sfc_pkg, sfc_out_stage and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one received byte per cycle while in_stall_o is low, hunts for the
// 32-bit sync word and then passes BODY_BYTES body bytes through with their
// offset; the last four body bytes are the received CRC (little-endian), and
// the final byte carries frame_end and crc_good. Hunting bytes, including the
// one that completes the sync word, give no result. Each accepted body byte's
// result is registered in the output stage, or in the skid buffer while the
// output waits. The CRC of the sync word is worked out ahead, one byte per
// cycle, so in_stall_o stays high after reset and after every register write
// until all four sync word bytes are done. A one-entry skid buffer lets input
// flow while a result waits on out_stall_i.
module sync_frame_crc32_checker_core #(
  parameter int unsigned BODY_BYTES = sfc_pkg::BodyBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   body_byte_o,
  output logic [sfc_pkg::OffsetW-1:0]  body_offset_o,
  output logic                         frame_end_o,
  output logic                         crc_good_o
);
  import sfc_pkg::*;

  localparam int unsigned CntW = $clog2(BODY_BYTES);
  localparam int unsigned ExtW = (CntW > OffsetW) ? CntW : OffsetW;
  localparam logic [CntW-1:0] LastCnt = CntW'(BODY_BYTES - 1);
  localparam logic [CntW-1:0] TailCnt = CntW'(BODY_BYTES - 4);

  logic [31:0]     crc_poly_q, sync_word_q;
  logic [31:0]     sync_shift_q, sync_shift_d;
  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     run_crc_q, run_crc_d;
  logic [31:0]     rcv_crc_q, rcv_crc_d;
  logic [31:0]     seed_crc_q, seed_crc_d;
  logic [1:0]      seed_idx_q, seed_idx_d;
  logic            seed_busy_q, seed_busy_d;
  logic [7:0]      seed_byte;
  logic [31:0]     shift_next;
  logic            in_acc;
  logic            last;
  logic [CntW-1:0] tail_pos;
  logic [ExtW-1:0] off_ext;
  logic            res_valid;
  logic            skid_full;
  result_t         res, out_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q  <= CrcPolyRst;
      sync_word_q <= SyncWordRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCrcPoly:  crc_poly_q  <= cfg_data_i;
        RegSyncWord: sync_word_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sync word bytes, most significant first
  always_comb begin
    case (seed_idx_q)
      2'd0:    seed_byte = sync_word_q[31:24];
      2'd1:    seed_byte = sync_word_q[23:16];
      2'd2:    seed_byte = sync_word_q[15:8];
      default: seed_byte = sync_word_q[7:0];
    endcase
  end

  // CRC of the sync word, one byte per cycle; restart on any register write.
  always_comb begin
    seed_crc_d  = seed_crc_q;
    seed_idx_d  = seed_idx_q;
    seed_busy_d = seed_busy_q;
    if (cfg_we_i) begin
      seed_crc_d  = 32'h0;
      seed_idx_d  = 2'd0;
      seed_busy_d = 1'b1;
    end else if (seed_busy_q) begin
      seed_crc_d = crc_byte(seed_crc_q, seed_byte, crc_poly_q);
      seed_idx_d = seed_idx_q + 2'd1;
      if (seed_idx_q == 2'd3) begin
        seed_busy_d = 1'b0;
      end
    end
  end

  assign in_stall_o = skid_full || seed_busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign shift_next = {sync_shift_q[23:0], rx_byte_i};
  assign last       = (cnt_q == LastCnt);
  assign tail_pos   = cnt_q - TailCnt;
  assign off_ext    = ExtW'(cnt_q);

  always_comb begin
    sync_shift_d = sync_shift_q;
    in_frame_d   = in_frame_q;
    cnt_d        = cnt_q;
    run_crc_d    = run_crc_q;
    rcv_crc_d    = rcv_crc_q;
    if (in_acc) begin
      if (!in_frame_q) begin
        sync_shift_d = shift_next;
        if (shift_next == sync_word_q) begin
          run_crc_d  = seed_crc_q;
          rcv_crc_d  = 32'h0;
          cnt_d      = '0;
          in_frame_d = 1'b1;
        end
      end else begin
        if (cnt_q < TailCnt) begin
          run_crc_d = crc_byte(run_crc_q, rx_byte_i, crc_poly_q);
        end else begin
          rcv_crc_d = rcv_crc_q | ({24'h0, rx_byte_i} << {tail_pos[1:0], 3'b000});
        end
        if (last) begin
          // Drop back to hunting with a clean shift register.
          in_frame_d   = 1'b0;
          sync_shift_d = 32'h0;
          cnt_d        = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_shift_q <= 32'h0;
      in_frame_q   <= 1'b0;
      cnt_q        <= '0;
      run_crc_q    <= 32'h0;
      rcv_crc_q    <= 32'h0;
      seed_crc_q   <= 32'h0;
      seed_idx_q   <= 2'd0;
      seed_busy_q  <= 1'b1;
    end else begin
      sync_shift_q <= sync_shift_d;
      in_frame_q   <= in_frame_d;
      cnt_q        <= cnt_d;
      run_crc_q    <= run_crc_d;
      rcv_crc_q    <= rcv_crc_d;
      seed_crc_q   <= seed_crc_d;
      seed_idx_q   <= seed_idx_d;
      seed_busy_q  <= seed_busy_d;
    end
  end

  assign res_valid       = in_acc && in_frame_q;
  assign res.body_byte   = rx_byte_i;
  assign res.body_offset = off_ext[OffsetW-1:0];
  assign res.frame_end   = last;
  assign res.crc_good    = last && (run_crc_q == rcv_crc_d);

  sfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign body_byte_o   = out_res.body_byte;
  assign body_offset_o = out_res.body_offset;
  assign frame_end_o   = out_res.frame_end;
  assign crc_good_o    = out_res.crc_good;

  `SFC_ASSERT(a_end_clears_hunt, clk_i, rst_ni,
              (in_acc && in_frame_q && last) |=> (!in_frame_q && sync_shift_q == 32'h0),
              "frame end did not return to a clean hunt")
  `SFC_ASSERT(a_cnt_in_range, clk_i, rst_ni, cnt_q <= LastCnt,
              "body byte counter ran past the frame length")
  `SFC_ASSERT(a_hunt_cnt_zero, clk_i, rst_ni, !in_frame_q |-> (cnt_q == '0),
              "body byte counter not zero while hunting")
  `SFC_ASSERT(a_good_only_at_end, clk_i, rst_ni, res.crc_good |-> res.frame_end,
              "crc_good raised on a byte that is not the frame end")
  `SFC_ASSERT(a_no_take_while_seeding, clk_i, rst_ni, seed_busy_q |-> !in_acc,
              "item accepted while the sync word CRC is not ready")
endmodule

### rtl/sfc_out_stage.sv
// Output register with a one-entry skid buffer for the framer result channel.
// Depends on sfc_pkg (result_t) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  sfc_pkg::result_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfc_pkg::result_t out_o
);
  import sfc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    slot_free;

  // Output slot frees when empty or when its item is taken this cycle.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (slot_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = res_valid_i;
        skid_d       = res_i;
      end else begin
        out_d       = res_i;
        out_valid_d = res_valid_i;
      end
    end else if (res_valid_i) begin
      // Hold the new item aside while the output waits.
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SFC_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q,
              "skid holds an item while the output register is empty")
  `SFC_ASSERT(a_skid_fill_cause, clk_i, rst_ni,
              $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i),
              "skid filled although the output slot was free")
  `SFC_ASSERT(a_no_overrun, clk_i, rst_ni, (skid_valid_q && out_stall_i) |-> !res_valid_i,
              "result produced while both stages are full")
endmodule
